[hdl/eafp_pkg.sv]
// ----------------------------------------------------------------------------
// eafp_pkg
// Shared constants, types and helper functions of the encoder angle
// frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eafp_pkg;

	localparam int FRAME_CHARS  = 11;
	localparam int FIELD_DIGITS = 5;

	localparam int IDX_W  = $clog2(FRAME_CHARS);
	localparam int WPOS_W = $clog2(FRAME_CHARS + 1);

	// signed raw field: magnitude up to 10**FIELD_DIGITS - 1
	localparam int MAG_W = $clog2(10 ** FIELD_DIGITS);
	localparam int RAW_W = MAG_W + 1;

	localparam int CFG_W   = 17;
	localparam int ANGLE_W = 18;
	localparam int DIFF_W  = ((RAW_W > CFG_W) ? RAW_W : CFG_W) + 2;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_BITS    = 2 * ANGLE_W + 2;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int ROLL_START  = 0;
	localparam int PITCH_START = FIELD_DIGITS + 1;

	typedef enum logic [1:0] {
		CFG_START_MARKER = 2'd0,
		CFG_END_MARKER   = 2'd1,
		CFG_ZERO_OFFSET  = 2'd2,
		CFG_ANGLE_LIMIT  = 2'd3
	} cfg_index_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [7:0]  RST_START_MARKER = 8'd44;
	localparam logic [7:0]  RST_END_MARKER   = 8'd47;
	localparam logic [CFG_W-1:0] RST_ZERO_OFFSET = CFG_W'(50000);
	localparam logic [CFG_W-1:0] RST_ANGLE_LIMIT = CFG_W'(6000);

	typedef logic [FRAME_CHARS-1:0][7:0] frame_chars_t;

	typedef struct packed {
		logic         valid;
		frame_chars_t chars;
	} snap_t;

	function automatic frame_chars_t frame_template();
		frame_chars_t t;
		int r;
		for (int p = 0; p < FRAME_CHARS; p++) begin
			r = p % (FIELD_DIGITS + 1);
			if (r == FIELD_DIGITS) begin
				t[p] = CH_UNDER;
			end else if (r == 0) begin
				t[p] = CH_FIVE;
			end else begin
				t[p] = CH_ZERO;
			end
		end
		return t;
	endfunction

	localparam frame_chars_t TEMPLATE = frame_template();

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Decimal read of one field: skip white space, one sign, then digits up
	// to the first non-digit. Positions past the buffer read as NUL.
	function automatic logic signed [RAW_W-1:0] parse_field(
		input frame_chars_t ch,
		input int           start
	);
		logic [7:0]       c;
		logic             ws;
		logic             done;
		logic             neg;
		logic [MAG_W-1:0] v;
		int               p;
		ws   = 1'b1;
		done = 1'b0;
		neg  = 1'b0;
		v    = '0;
		for (int i = 0; i < FIELD_DIGITS; i++) begin
			p = start + i;
			c = (p < FRAME_CHARS) ? ch[IDX_W'(p)] : CH_NUL;
			if (!done) begin
				if (ws && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
					ws = 1'b1;
				end else if (ws) begin
					ws = 1'b0;
					if (c == CH_MINUS) begin
						neg = 1'b1;
					end else if (c == CH_PLUS) begin
						neg = 1'b0;
					end else if (is_digit(c)) begin
						v = MAG_W'(v * 10 + MAG_W'(c - CH_ZERO));
					end else begin
						done = 1'b1;
					end
				end else if (is_digit(c)) begin
					v = MAG_W'(v * 10 + MAG_W'(c - CH_ZERO));
				end else begin
					done = 1'b1;
				end
			end
		end
		return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

endpackage

`default_nettype wire

[hdl/eafp_framer.sv]
// ----------------------------------------------------------------------------
// eafp_framer
// Frame tracking: holds the in-frame flag, write position and character
// buffer, and captures a snapshot of the buffer when the end marker closes
// a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eafp_framer import eafp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic       rx_valid,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] start_marker,
	input  wire logic [7:0] end_marker,
	output snap_t           snap_s1
);

	logic              in_frame_q;
	logic [WPOS_W-1:0] wpos_q;
	frame_chars_t      chars_q;
	frame_chars_t      closed_chars;
	logic              take;
	logic              is_end;
	logic              is_start;

	assign take     = advance && rx_valid;
	assign is_end   = (rx_byte == end_marker);
	assign is_start = (rx_byte == start_marker);

	// a short frame ends its number with a NUL at the write position
	always_comb begin
		for (int p = 0; p < FRAME_CHARS; p++) begin
			closed_chars[p] = (wpos_q == WPOS_W'(p)) ? CH_NUL : chars_q[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			wpos_q        <= '0;
			chars_q       <= TEMPLATE;
			snap_s1.valid <= 1'b0;
			snap_s1.chars <= TEMPLATE;
		end else if (advance) begin
			snap_s1.valid <= take && in_frame_q && is_end;
			snap_s1.chars <= closed_chars;
			if (take) begin
				if (!in_frame_q) begin
					if (is_start) begin
						in_frame_q <= 1'b1;
						wpos_q     <= '0;
						chars_q    <= TEMPLATE;
					end
				end else if (!is_end) begin
					// drop bytes once the buffer is full
					if (wpos_q < WPOS_W'(FRAME_CHARS)) begin
						chars_q[wpos_q[IDX_W-1:0]] <= rx_byte;
						wpos_q                      <= wpos_q + 1'b1;
					end
				end else begin
					in_frame_q <= 1'b0;
					wpos_q     <= '0;
				end
			end
		end
	end

	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= WPOS_W'(FRAME_CHARS))
		else $error("write position past frame length");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> wpos_q == '0)
		else $error("write position nonzero outside a frame");

	a_snap_closes: assert property (@(posedge clk) disable iff (!arst_n)
		snap_s1.valid && $past(advance) |-> $past(in_frame_q) && !in_frame_q)
		else $error("snapshot taken without closing a frame");

endmodule

`default_nettype wire

[hdl/eafp_convert.sv]
// ----------------------------------------------------------------------------
// eafp_convert
// Field conversion: decimal read of both fields, then offset removal and
// clamping into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eafp_convert import eafp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  snap_t                   snap_s1,
	input  wire logic [CFG_W-1:0]   zero_offset,
	input  wire logic [CFG_W-1:0]   angle_limit,
	output logic                    out_valid_q,
	output logic signed [ANGLE_W-1:0] roll_q,
	output logic signed [ANGLE_W-1:0] pitch_q,
	output logic                    roll_clamped_q,
	output logic                    pitch_clamped_q
);

	logic                    valid_s2;
	logic signed [RAW_W-1:0] roll_raw_s2;
	logic signed [RAW_W-1:0] pitch_raw_s2;

	logic signed [DIFF_W-1:0]  lim;
	logic signed [DIFF_W-1:0]  roll_d;
	logic signed [DIFF_W-1:0]  pitch_d;
	logic signed [DIFF_W-1:0]  roll_c;
	logic signed [DIFF_W-1:0]  pitch_c;
	logic                      roll_f;
	logic                      pitch_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= snap_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			roll_raw_s2  <= parse_field(snap_s1.chars, ROLL_START);
			pitch_raw_s2 <= parse_field(snap_s1.chars, PITCH_START);
		end
	end

	assign lim     = $signed(DIFF_W'(angle_limit));
	assign roll_d  = DIFF_W'(roll_raw_s2) - $signed(DIFF_W'(zero_offset));
	assign pitch_d = DIFF_W'(pitch_raw_s2) - $signed(DIFF_W'(zero_offset));

	// values inside the limit pass through unflagged
	always_comb begin
		roll_c = roll_d;
		roll_f = 1'b0;
		if (roll_d > lim) begin
			roll_c = lim;
			roll_f = 1'b1;
		end else if (roll_d < -lim) begin
			roll_c = -lim;
			roll_f = 1'b1;
		end
		pitch_c = pitch_d;
		pitch_f = 1'b0;
		if (pitch_d > lim) begin
			pitch_c = lim;
			pitch_f = 1'b1;
		end else if (pitch_d < -lim) begin
			pitch_c = -lim;
			pitch_f = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			roll_q          <= roll_c[ANGLE_W-1:0];
			pitch_q         <= pitch_c[ANGLE_W-1:0];
			roll_clamped_q  <= roll_f;
			pitch_clamped_q <= pitch_f;
		end
	end

	a_roll_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (roll_q <= $signed({1'b0, angle_limit}))
			&& (roll_q >= -$signed({1'b0, angle_limit})))
		else $error("roll result outside the limit");

	a_flag_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && roll_clamped_q |->
			(roll_q == $signed({1'b0, angle_limit}))
			|| (roll_q == -$signed({1'b0, angle_limit})))
		else $error("roll flagged clamped but not at the limit");

endmodule

`default_nettype wire

[hdl/encoder_angle_frame_parser.sv]
// ----------------------------------------------------------------------------
// encoder_angle_frame_parser
// Finds start/end marked frames in a received byte stream and turns the two
// decimal fields into clamped roll and pitch angles.
// ----------------------------------------------------------------------------
// Pipeline: a result leaves through three registered stages after the end
// marker transfer (frame snapshot, decimal read, offset and clamp).
// Throughput: one byte per cycle; the three-stage pipeline stalls as a whole
// only while the output register holds a result that is not taken.
// Reset: asynchronous, active low; clears the frame state, loads the
// "50000_50000" template and the default marker, offset and limit values.
`timescale 1ns / 1ps
`default_nettype none

module encoder_angle_frame_parser import eafp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [17:0] roll_angle, [35:18] pitch_angle, [36] roll_clamped,
	// [37] pitch_clamped, [39:38] zero
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	logic [7:0]       start_marker_q;
	logic [7:0]       end_marker_q;
	logic [CFG_W-1:0] zero_offset_q;
	logic [CFG_W-1:0] angle_limit_q;

	logic                     advance;
	snap_t                    snap_s1;
	logic                     out_valid_q;
	logic signed [ANGLE_W-1:0] roll_q;
	logic signed [ANGLE_W-1:0] pitch_q;
	logic                     roll_clamped_q;
	logic                     pitch_clamped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= RST_START_MARKER;
			end_marker_q   <= RST_END_MARKER;
			zero_offset_q  <= RST_ZERO_OFFSET;
			angle_limit_q  <= RST_ANGLE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_START_MARKER: start_marker_q <= cfg_data[7:0];
				CFG_END_MARKER:   end_marker_q   <= cfg_data[7:0];
				CFG_ZERO_OFFSET:  zero_offset_q  <= cfg_data;
				CFG_ANGLE_LIMIT:  angle_limit_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	// advance the pipeline whenever the output register is free or drains
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;

	eafp_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.rx_valid     (s_tvalid),
		.rx_byte      (s_tdata[7:0]),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.snap_s1      (snap_s1)
	);

	eafp_convert u_convert (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.snap_s1         (snap_s1),
		.zero_offset     (zero_offset_q),
		.angle_limit     (angle_limit_q),
		.out_valid_q     (out_valid_q),
		.roll_q          (roll_q),
		.pitch_q         (pitch_q),
		.roll_clamped_q  (roll_clamped_q),
		.pitch_clamped_q (pitch_clamped_q)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), pitch_clamped_q, roll_clamped_q,
		pitch_q, roll_q};

endmodule

`default_nettype wire
